FILE: sv/utc_local_datetime_shift_unit_defines.svh
// assertion macros shared by the utc shift rtl
// no dependencies; included by the files that carry concurrent checks
`ifndef UTC_LOCAL_DATETIME_SHIFT_UNIT_DEFINES_SVH
`define UTC_LOCAL_DATETIME_SHIFT_UNIT_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define UTCS_CHECK_IMP(lbl, clk_s, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is low
`define UTCS_CHECK_NEXT(lbl, clk_s, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/utcs_pkg.sv
// types, constants and small tables for the utc date-time shift pipeline
// no dependencies; used by utcs_days_to_civil, the top level and the testbench
package utcs_pkg;

	localparam int STAGES        = 9;
	localparam int MIN_PER_DAY   = 1440;
	localparam int DAYS_PER_ERA  = 146097;
	localparam int YEARS_PER_ERA = 400;
	localparam int DAYS_PER_CENT = 36524;

	// floor(x / 365) = (x * RCP_365) >> 27 and floor(x / 1460) = (x * RCP_365) >> 29,
	// both exact for x below 2**18
	localparam logic [18:0] RCP_365  = 19'd367720;
	localparam int          SH_365   = 27;
	localparam int          SH_1460  = 29;
	// floor(x / 60) = (x * RCP_60) >> 17, exact for x below 2**11
	localparam logic [11:0] RCP_60   = 12'd2185;
	localparam int          SH_60    = 17;

	typedef logic signed [10:0] offset_t;
	typedef logic signed [21:0] day_num_t;
	typedef logic signed [4:0]  era_t;

	typedef struct packed {
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
	} hms_t;

	// load enables for the date stages inside utcs_days_to_civil
	typedef struct packed {
		logic s4;
		logic s5;
		logic s6;
		logic s7;
		logic s8;
		logic s9;
	} stage_en_t;

	// first day of each month in a year that starts in march
	function automatic logic [8:0] month_start(input logic [3:0] mp);
		logic [8:0] r;
		case (mp)
			4'd0:    r = 9'd0;
			4'd1:    r = 9'd31;
			4'd2:    r = 9'd61;
			4'd3:    r = 9'd92;
			4'd4:    r = 9'd122;
			4'd5:    r = 9'd153;
			4'd6:    r = 9'd184;
			4'd7:    r = 9'd214;
			4'd8:    r = 9'd245;
			4'd9:    r = 9'd275;
			4'd10:   r = 9'd306;
			4'd11:   r = 9'd337;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

	// year of era divided by 100, year of era below 400
	function automatic logic [1:0] cent_of(input logic [8:0] yoe);
		logic [1:0] c;
		c = 2'(yoe >= 9'd100) + 2'(yoe >= 9'd200) + 2'(yoe >= 9'd300);
		return c;
	endfunction

endpackage

FILE: sv/utcs_ifs.sv
// valid/ready channel interfaces for the utc date-time shift unit
// no dependencies
interface utcs_in_if;
	logic        valid;
	logic        ready;
	logic        action;
	logic [11:0] year;
	logic [3:0]  month;
	logic [4:0]  day;
	logic [4:0]  hour;
	logic [5:0]  minute;
	logic [5:0]  second;

	modport source (output valid, action, year, month, day, hour, minute, second,
		input ready);
	modport sink (input valid, action, year, month, day, hour, minute, second,
		output ready);
endinterface

interface utcs_out_if;
	logic        valid;
	logic        ready;
	logic [11:0] out_year;
	logic [3:0]  out_month;
	logic [4:0]  out_day;
	logic [4:0]  out_hour;
	logic [5:0]  out_minute;
	logic [5:0]  out_second;

	modport source (output valid, out_year, out_month, out_day, out_hour, out_minute,
		out_second, input ready);
	modport sink (input valid, out_year, out_month, out_day, out_hour, out_minute,
		out_second, output ready);
endinterface

FILE: sv/utcs_days_to_civil.sv
// day number to gregorian year, month and day, stages four to nine
// depends on utcs_pkg
module utcs_days_to_civil (
	input  logic               clk,
	input  utcs_pkg::stage_en_t en,
	input  utcs_pkg::day_num_t  z,
	output logic [11:0]        year,
	output logic [3:0]         month,
	output logic [4:0]         day
);
	import utcs_pkg::*;

	// stage 4: era by comparing against era boundaries
	logic [3:0] ecnt4;
	era_t       era4;
	day_num_t   z_s4;
	era_t       era_s4;

	always_comb begin
		ecnt4 = 4'd0;
		for (int j = 0; j <= 12; j++) begin
			if (z >= $signed(22'((j - 1) * DAYS_PER_ERA)))
				ecnt4 = ecnt4 + 4'd1;
		end
		era4 = $signed({1'b0, ecnt4}) - 5'sd2;
	end

	always_ff @(posedge clk) begin
		if (en.s4) begin
			z_s4   <= z;
			era_s4 <= era4;
		end
	end

	// stage 5: day of era
	day_num_t    doe5;
	logic [17:0] doe_s5;
	era_t        era_s5;

	assign doe5 = z_s4 - $signed({{17{era_s4[4]}}, era_s4}) * 22'sd146097;

	always_ff @(posedge clk) begin
		if (en.s5) begin
			doe_s5 <= doe5[17:0];
			era_s5 <= era_s4;
		end
	end

	// stage 6: four-year and century counts
	logic [36:0] prod6;
	logic [2:0]  cn6;
	logic [6:0]  q_s6;
	logic [2:0]  cn_s6;
	logic [17:0] doe_s6;
	era_t        era_s6;

	always_comb begin
		prod6 = 37'(doe_s5) * 37'(RCP_365);
		cn6 = 3'd0;
		for (int k = 1; k <= 4; k++) begin
			if (doe_s5 >= 18'(k * DAYS_PER_CENT))
				cn6 = cn6 + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (en.s6) begin
			q_s6   <= 7'(prod6 >> SH_1460);
			cn_s6  <= cn6;
			doe_s6 <= doe_s5;
			era_s6 <= era_s5;
		end
	end

	// stage 7: year of era; the last day of an era counts three centuries, not four
	logic [17:0] x7;
	logic [36:0] prod7;
	logic [8:0]  yoe_s7;
	logic [17:0] doe_s7;
	era_t        era_s7;

	assign x7    = doe_s6 - 18'(q_s6) + 18'(cn_s6) - 18'(cn_s6[2]);
	assign prod7 = 37'(x7) * 37'(RCP_365);

	always_ff @(posedge clk) begin
		if (en.s7) begin
			yoe_s7 <= 9'(prod7 >> SH_365);
			doe_s7 <= doe_s6;
			era_s7 <= era_s6;
		end
	end

	// stage 8: day of year and full year
	logic [17:0]        yd8;
	logic [17:0]        doy8;
	logic signed [13:0] yy8;
	logic [8:0]         doy_s8;
	logic signed [13:0] yy_s8;

	always_comb begin
		yd8  = 18'(yoe_s7) * 18'd365 + 18'(yoe_s7[8:2]) - 18'(cent_of(yoe_s7));
		doy8 = doe_s7 - yd8;
		yy8  = $signed({5'd0, yoe_s7}) + $signed({{9{era_s7[4]}}, era_s7}) * 14'sd400;
	end

	always_ff @(posedge clk) begin
		if (en.s8) begin
			doy_s8 <= doy8[8:0];
			yy_s8  <= yy8;
		end
	end

	// stage 9: month search over the month starts
	logic [3:0]         mp9;
	logic [8:0]         dd9;
	logic [3:0]         mm9;
	logic signed [13:0] yy9;
	logic [11:0]        year_s9;
	logic [3:0]         month_s9;
	logic [4:0]         day_s9;

	always_comb begin
		mp9 = 4'd0;
		for (int k = 1; k <= 11; k++) begin
			if (doy_s8 >= month_start(4'(k)))
				mp9 = mp9 + 4'd1;
		end
		dd9 = doy_s8 - month_start(mp9) + 9'd1;
		// january and february belong to the next year
		mm9 = (mp9 < 4'd10) ? mp9 + 4'd3 : mp9 - 4'd9;
		yy9 = yy_s8 + $signed({13'd0, (mp9 >= 4'd10)});
	end

	always_ff @(posedge clk) begin
		if (en.s9) begin
			year_s9  <= yy9[11:0];
			month_s9 <= mm9;
			day_s9   <= dd9[4:0];
		end
	end

	assign year  = year_s9;
	assign month = month_s9;
	assign day   = day_s9;

endmodule

FILE: sv/utc_local_datetime_shift_unit.sv
// top level of the utc / local date-time shift pipeline
// depends on utcs_pkg, utcs_ifs and utcs_days_to_civil
//
// din carries one date-time word per handshake: action 0 moves it from utc to
// local time by adding the programmed offset, action 1 subtracts it. dout
// carries the shifted year, month, day, hour, minute and second, one word for
// every word accepted, in order. cfg_we writes the signed minute offset from
// cfg_wdata; write it only while the pipeline holds no words.
// Throughput is one word per cycle while dout accepts. The nine register
// stages are date to day number (three stages), era search, day of era, the
// two reciprocal multiplies for the year of era, day of year, month search.
// Reset clears all stage valid bits and sets the offset to zero.
// When dout is stalled the last stage holds its word; earlier stages keep
// moving into empty slots, so din.ready falls only once all nine stages hold
// a word, and nothing is dropped or repeated.
`include "utc_local_datetime_shift_unit_defines.svh"

module utc_local_datetime_shift_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  utcs_pkg::offset_t cfg_wdata,
	utcs_in_if.sink           din,
	utcs_out_if.source        dout
);
	import utcs_pkg::*;

	// offset register
	offset_t off_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q <= '0;
		end else if (cfg_we) begin
			off_q <= cfg_wdata;
		end
	end

	// stage control: a stage loads when it is empty or its word moves on
	logic [STAGES-1:0] stage_vld_q;
	logic [STAGES:0]   rdy;

	always_comb begin
		rdy[STAGES] = dout.ready;
		for (int i = STAGES - 1; i >= 0; i--) begin
			rdy[i] = !stage_vld_q[i] || rdy[i+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_vld_q <= '0;
		end else begin
			if (rdy[0])
				stage_vld_q[0] <= din.valid;
			for (int i = 1; i < STAGES; i++) begin
				if (rdy[i])
					stage_vld_q[i] <= stage_vld_q[i-1];
			end
		end
	end

	assign din.ready  = rdy[0];
	assign dout.valid = stage_vld_q[STAGES-1];

	// stage 1: month clamp, march-based year, era, day of year, total minutes
	logic [3:0]         mon_c;
	logic               feb;
	logic signed [12:0] y0;
	era_t               era0;
	logic [3:0]         mpi;
	logic signed [9:0]  doy0;
	logic               sc0;
	logic [5:0]         sec0;
	logic signed [11:0] shift0;
	logic [10:0]        hm0;
	logic signed [12:0] tmin0;

	always_comb begin
		mon_c = din.month;
		if (din.month == 4'd0)
			mon_c = 4'd1;
		else if (din.month > 4'd12)
			mon_c = 4'd12;
		feb = (mon_c <= 4'd2);
		y0  = $signed({1'b0, din.year}) - $signed({12'd0, feb});
		era0 = y0[12] ? -5'sd1 : 5'sd0;
		for (int k = 1; k <= 10; k++) begin
			if (y0 >= $signed(13'(k * YEARS_PER_ERA)))
				era0 = era0 + 5'sd1;
		end
		mpi  = feb ? mon_c + 4'd9 : mon_c - 4'd3;
		doy0 = $signed({1'b0, month_start(mpi)}) + $signed({5'd0, din.day}) - 10'sd1;
		// seconds never exceed 63, so at most one minute carries out
		sc0  = (din.second >= 6'd60);
		sec0 = sc0 ? din.second - 6'd60 : din.second;
		shift0 = din.action ? -$signed({off_q[10], off_q}) : $signed({off_q[10], off_q});
		hm0    = 11'(din.hour) * 11'd60;
		tmin0  = $signed({2'b00, hm0}) + $signed({7'd0, din.minute})
			+ $signed({12'd0, sc0}) + $signed({shift0[11], shift0});
	end

	logic signed [12:0] y_s1;
	era_t               era_s1;
	logic signed [9:0]  doy_s1;
	logic signed [12:0] tmin_s1;
	logic [5:0]         sec_s1;

	always_ff @(posedge clk) begin
		if (rdy[0]) begin
			y_s1    <= y0;
			era_s1  <= era0;
			doy_s1  <= doy0;
			tmin_s1 <= tmin0;
			sec_s1  <= sec0;
		end
	end

	// stage 2: year of era, day carry from the minutes
	logic signed [13:0] yoe_w1;
	logic signed [2:0]  tc1;
	logic signed [12:0] tmod_w1;

	always_comb begin
		yoe_w1 = $signed({y_s1[12], y_s1})
			- $signed({{9{era_s1[4]}}, era_s1}) * 14'sd400;
		if (tmin_s1 < 13'sd0)
			tc1 = -3'sd1;
		else if (tmin_s1 >= 13'sd2880)
			tc1 = 3'sd2;
		else if (tmin_s1 >= 13'sd1440)
			tc1 = 3'sd1;
		else
			tc1 = 3'sd0;
		tmod_w1 = tmin_s1 - $signed({{10{tc1[2]}}, tc1}) * 13'sd1440;
	end

	era_t              era_s2;
	logic [8:0]        yoe_s2;
	logic signed [9:0] doy_s2;
	logic signed [2:0] tc_s2;
	logic [10:0]       tmod_s2;
	logic [5:0]        sec_s2;

	always_ff @(posedge clk) begin
		if (rdy[1]) begin
			era_s2  <= era_s1;
			yoe_s2  <= yoe_w1[8:0];
			doy_s2  <= doy_s1;
			tc_s2   <= tc1;
			tmod_s2 <= tmod_w1[10:0];
			sec_s2  <= sec_s1;
		end
	end

	// stage 3: day number with the carry folded in, hour of day
	logic [17:0] yd2;
	day_num_t    z2;
	logic [22:0] hp2;

	always_comb begin
		yd2 = 18'(yoe_s2) * 18'd365 + 18'(yoe_s2[8:2]) - 18'(cent_of(yoe_s2));
		z2  = $signed({{17{era_s2[4]}}, era_s2}) * 22'sd146097
			+ $signed({4'd0, yd2})
			+ $signed({{12{doy_s2[9]}}, doy_s2})
			+ $signed({{19{tc_s2[2]}}, tc_s2});
		hp2 = 23'(tmod_s2) * 23'(RCP_60);
	end

	day_num_t    z_s3;
	logic [10:0] tmod_s3;
	logic [4:0]  hour_s3;
	logic [5:0]  sec_s3;

	always_ff @(posedge clk) begin
		if (rdy[2]) begin
			z_s3    <= z2;
			tmod_s3 <= tmod_s2;
			hour_s3 <= 5'(hp2 >> SH_60);
			sec_s3  <= sec_s2;
		end
	end

	// stages 4 to 9: time of day rides along with the date conversion
	logic [10:0] min_w3;
	hms_t        tm_s4;
	hms_t        tm_s5;
	hms_t        tm_s6;
	hms_t        tm_s7;
	hms_t        tm_s8;
	hms_t        tm_s9;

	assign min_w3 = tmod_s3 - 11'(hour_s3) * 11'd60;

	always_ff @(posedge clk) begin
		if (rdy[3]) begin
			tm_s4.hour   <= hour_s3;
			tm_s4.minute <= min_w3[5:0];
			tm_s4.second <= sec_s3;
		end
		if (rdy[4])
			tm_s5 <= tm_s4;
		if (rdy[5])
			tm_s6 <= tm_s5;
		if (rdy[6])
			tm_s7 <= tm_s6;
		if (rdy[7])
			tm_s8 <= tm_s7;
		if (rdy[8])
			tm_s9 <= tm_s8;
	end

	stage_en_t civ_en;

	assign civ_en.s4 = rdy[3];
	assign civ_en.s5 = rdy[4];
	assign civ_en.s6 = rdy[5];
	assign civ_en.s7 = rdy[6];
	assign civ_en.s8 = rdy[7];
	assign civ_en.s9 = rdy[8];

	utcs_days_to_civil u_civil (
		.clk   (clk),
		.en    (civ_en),
		.z     (z_s3),
		.year  (dout.out_year),
		.month (dout.out_month),
		.day   (dout.out_day)
	);

	assign dout.out_hour   = tm_s9.hour;
	assign dout.out_minute = tm_s9.minute;
	assign dout.out_second = tm_s9.second;

	`UTCS_CHECK_NEXT(a_accept_fills_s1, clk, arst_n, din.valid && din.ready,
		stage_vld_q[0], "accepted word did not reach stage one")
	`UTCS_CHECK_IMP(a_minute_of_day, clk, arst_n, stage_vld_q[1],
		tmod_s2 < 11'(MIN_PER_DAY), "minute of day out of range after day carry")
	`UTCS_CHECK_IMP(a_time_fields, clk, arst_n, dout.valid,
		(dout.out_hour < 5'd24) && (dout.out_minute < 6'd60) && (dout.out_second < 6'd60),
		"output time field out of range")
	`UTCS_CHECK_IMP(a_date_fields, clk, arst_n, dout.valid,
		(dout.out_month >= 4'd1) && (dout.out_month <= 4'd12) && (dout.out_day >= 5'd1),
		"output month or day out of range")

endmodule

FILE: tb/tb_utc_local_datetime_shift_unit.sv
`timescale 1ns / 100ps
// self-checking testbench for the utc / local date-time shift unit
// depends on utcs_pkg, utcs_ifs and utc_local_datetime_shift_unit; predicts every word in-bench
module tb_utc_local_datetime_shift_unit;

	localparam bit TO_LOCAL = 1'b0;
	localparam bit TO_UTC   = 1'b1;

	localparam longint SECS_IN_DAY  = 86400;
	localparam longint DAYS_IN_ERA  = 146097;
	localparam longint MARCH_EPOCH  = 719468;

	localparam int N_PHASES       = 8;
	localparam int PHASE_WORDS    = 88;
	localparam int HOLD_CYCLES    = 80;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int N_DIRECTED     = 23;

	typedef struct packed {
		logic        action;
		logic [11:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
	} stamp_t;

	typedef struct packed {
		logic [11:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
	} shifted_t;

	typedef struct packed {
		utcs_pkg::offset_t ofs;
		stamp_t            word;
		logic              known;
		shifted_t          want;
	} dir_row_t;

	typedef struct {
		bit       known;
		shifted_t value;
	} answer_t;

	// rows with known set carry an answer worked out by hand
	localparam dir_row_t STEPS [N_DIRECTED] = '{
		'{0,     '{TO_LOCAL, 2024, 2, 29, 12, 34, 56}, 1, '{2024, 2, 29, 12, 34, 56}},
		'{0,     '{TO_UTC,   1900, 1, 1, 0, 0, 0},     1, '{1900, 1, 1, 0, 0, 0}},
		'{0,     '{TO_LOCAL, 0, 0, 0, 0, 0, 0},        1, '{4095, 12, 31, 0, 0, 0}},
		'{840,   '{TO_LOCAL, 2199, 12, 31, 23, 59, 59}, 1, '{2200, 1, 1, 13, 59, 59}},
		'{840,   '{TO_UTC,   1900, 1, 1, 0, 0, 0},     1, '{1899, 12, 31, 10, 0, 0}},
		'{840,   '{TO_UTC,   4095, 15, 31, 31, 63, 63}, 0, '{0, 0, 0, 0, 0, 0}},
		'{-720,  '{TO_LOCAL, 1900, 1, 1, 0, 0, 0},     1, '{1899, 12, 31, 12, 0, 0}},
		'{-720,  '{TO_UTC,   2199, 12, 31, 23, 59, 59}, 1, '{2200, 1, 1, 11, 59, 59}},
		'{-720,  '{TO_LOCAL, 2000, 3, 1, 5, 30, 0},    1, '{2000, 2, 29, 17, 30, 0}},
		'{1023,  '{TO_LOCAL, 2100, 2, 28, 23, 0, 0},   0, '{0, 0, 0, 0, 0, 0}},
		'{1023,  '{TO_UTC,   2050, 6, 15, 8, 45, 10},  0, '{0, 0, 0, 0, 0, 0}},
		'{-1024, '{TO_LOCAL, 2023, 3, 1, 0, 0, 0},     0, '{0, 0, 0, 0, 0, 0}},
		'{-1024, '{TO_UTC,   1999, 12, 31, 23, 59, 59}, 0, '{0, 0, 0, 0, 0, 0}},
		'{330,   '{TO_LOCAL, 2021, 0, 15, 10, 0, 0},   0, '{0, 0, 0, 0, 0, 0}},
		'{330,   '{TO_LOCAL, 2021, 15, 15, 10, 0, 0},  0, '{0, 0, 0, 0, 0, 0}},
		'{330,   '{TO_LOCAL, 2021, 3, 0, 10, 0, 0},    0, '{0, 0, 0, 0, 0, 0}},
		'{330,   '{TO_UTC,   2023, 2, 31, 10, 0, 0},   0, '{0, 0, 0, 0, 0, 0}},
		'{330,   '{TO_LOCAL, 2022, 7, 4, 31, 63, 63},  0, '{0, 0, 0, 0, 0, 0}},
		'{330,   '{TO_UTC,   0, 1, 1, 0, 0, 0},        1, '{4095, 12, 31, 18, 30, 0}},
		'{330,   '{TO_LOCAL, 4095, 12, 31, 23, 59, 59}, 1, '{0, 1, 1, 5, 29, 59}},
		'{-1,    '{TO_LOCAL, 1900, 3, 1, 0, 0, 0},     1, '{1900, 2, 28, 23, 59, 0}},
		'{1,     '{TO_UTC,   2000, 3, 1, 0, 0, 0},     1, '{2000, 2, 29, 23, 59, 0}},
		'{1,     '{TO_LOCAL, 2023, 12, 31, 23, 59, 30}, 1, '{2024, 1, 1, 0, 0, 30}}
	};

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	utcs_pkg::offset_t cfg_wdata;

	utcs_in_if  din_w ();
	utcs_out_if dout_w ();

	utc_local_datetime_shift_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.din       (din_w),
		.dout      (dout_w)
	);

	shifted_t          due_results [$];
	answer_t           typed_answers [$];
	utcs_pkg::offset_t live_offset = '0;
	int                mismatches = 0;
	int                words_checked = 0;
	int                offsets_loaded = 0;
	int                quiet_cycles = 0;
	bit                no_idle = 1'b0;
	bit                hold_dout_req = 1'b0;

	function automatic longint floor_quot(input longint a, input longint b);
		longint q;
		q = a / b;
		if ((a % b) != 0 && ((a < 0) != (b < 0)))
			q = q - 1;
		return q;
	endfunction

	// proleptic gregorian date to day count, year taken to start in march
	function automatic longint civil_to_day_count(input longint y, input longint m,
		input longint d);
		longint yy, era, yoe, doy, doe;
		yy = (m <= 2) ? y - 1 : y;
		era = floor_quot(yy, 400);
		yoe = yy - era * 400;
		doy = (153 * (m > 2 ? m - 3 : m + 9) + 2) / 5 + d - 1;
		doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
		return era * DAYS_IN_ERA + doe - MARCH_EPOCH;
	endfunction

	function automatic void day_count_to_civil(input longint z, output longint y,
		output longint m, output longint d);
		longint zz, era, doe, yoe, doy, mp;
		zz = z + MARCH_EPOCH;
		era = floor_quot(zz, DAYS_IN_ERA);
		doe = zz - era * DAYS_IN_ERA;
		yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
		doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
		mp = (5 * doy + 2) / 153;
		d = doy - (153 * mp + 2) / 5 + 1;
		m = (mp < 10) ? mp + 3 : mp - 9;
		y = yoe + era * 400 + ((m <= 2) ? 1 : 0);
	endfunction

	function automatic shifted_t shift_datetime(input stamp_t w, input utcs_pkg::offset_t ofs);
		longint mon, mins, days, sod, carry, yy, mm, dd;
		shifted_t r;
		mon = w.month;
		if (mon < 1)
			mon = 1;
		if (mon > 12)
			mon = 12;
		mins = (w.action == TO_UTC) ? -longint'(ofs) : longint'(ofs);
		days = civil_to_day_count(longint'(w.year), mon, longint'(w.day));
		sod = longint'(w.hour) * 3600 + longint'(w.minute) * 60 + longint'(w.second) + mins * 60;
		carry = floor_quot(sod, SECS_IN_DAY);
		sod = sod - carry * SECS_IN_DAY;
		days = days + carry;
		day_count_to_civil(days, yy, mm, dd);
		r.year   = 12'(yy);
		r.month  = 4'(mm);
		r.day    = 5'(dd);
		r.hour   = 5'(sod / 3600);
		r.minute = 6'((sod / 60) % 60);
		r.second = 6'(sod % 60);
		return r;
	endfunction

	// mostly calendar-valid words, with a share of out-of-range fields
	function automatic stamp_t random_datetime();
		stamp_t w;
		int pick;
		w.action = 1'($urandom_range(1));
		w.year   = ($urandom_range(99) < 80) ? 12'($urandom_range(2199, 1900))
			: 12'($urandom_range(4095));
		w.month  = ($urandom_range(99) < 90) ? 4'($urandom_range(12, 1)) : 4'($urandom_range(15));
		pick = $urandom_range(99);
		if (pick < 60)
			w.day = 5'($urandom_range(28, 1));
		else if (pick < 85)
			w.day = 5'($urandom_range(31, 28));
		else
			w.day = 5'($urandom_range(31));
		w.hour   = ($urandom_range(99) < 90) ? 5'($urandom_range(23)) : 5'($urandom_range(31));
		w.minute = ($urandom_range(99) < 90) ? 6'($urandom_range(59)) : 6'($urandom_range(63));
		w.second = ($urandom_range(99) < 90) ? 6'($urandom_range(59)) : 6'($urandom_range(63));
		return w;
	endfunction

	task automatic flag_mismatch(input string what, input int got, input int want);
		$display("%0t mismatch on %s: got %0d, expected %0d", $time, what, got, want);
		mismatches++;
	endtask

	task automatic offer_word(input stamp_t w, input bit known, input shifted_t value);
		typed_answers.push_back(answer_t'{known, value});
		din_w.valid  <= 1'b1;
		din_w.action <= w.action;
		din_w.year   <= w.year;
		din_w.month  <= w.month;
		din_w.day    <= w.day;
		din_w.hour   <= w.hour;
		din_w.minute <= w.minute;
		din_w.second <= w.second;
		do @(posedge clk); while (!din_w.ready);
	endtask

	// stop offering and wait for the pipeline to hand back every word
	task automatic settle();
		din_w.valid <= 1'b0;
		while (due_results.size() != 0 || typed_answers.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic load_offset(input utcs_pkg::offset_t v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		offsets_loaded++;
	endtask

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// sink side: random back-pressure, one long hold on request
	initial begin
		dout_w.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_dout_req) begin
				hold_dout_req = 1'b0;
				dout_w.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				dout_w.ready <= no_idle || ($urandom_range(99) >= 7);
			end
		end
	end

	always @(posedge clk) begin
		stamp_t    w;
		answer_t   hint;
		shifted_t  want;
		shifted_t  got;
		if (cfg_we)
			live_offset = cfg_wdata;
		if (din_w.valid && din_w.ready) begin
			w = '{din_w.action, din_w.year, din_w.month, din_w.day, din_w.hour,
				din_w.minute, din_w.second};
			if (typed_answers.size() != 0)
				hint = typed_answers.pop_front();
			else
				hint = '{1'b0, '0};
			want = hint.known ? hint.value : shift_datetime(w, live_offset);
			due_results.push_back(want);
		end
		if (dout_w.valid && dout_w.ready) begin
			got = '{dout_w.out_year, dout_w.out_month, dout_w.out_day, dout_w.out_hour,
				dout_w.out_minute, dout_w.out_second};
			if (due_results.size() == 0) begin
				flag_mismatch("unexpected word", 0, 0);
			end else begin
				want = due_results.pop_front();
				words_checked++;
				if (got.year !== want.year)
					flag_mismatch("out_year", int'(got.year), int'(want.year));
				if (got.month !== want.month)
					flag_mismatch("out_month", int'(got.month), int'(want.month));
				if (got.day !== want.day)
					flag_mismatch("out_day", int'(got.day), int'(want.day));
				if (got.hour !== want.hour)
					flag_mismatch("out_hour", int'(got.hour), int'(want.hour));
				if (got.minute !== want.minute)
					flag_mismatch("out_minute", int'(got.minute), int'(want.minute));
				if (got.second !== want.second)
					flag_mismatch("out_second", int'(got.second), int'(want.second));
			end
		end
	end

	always @(posedge clk) begin
		if ((din_w.valid && din_w.ready) || (dout_w.valid && dout_w.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
			$display("[utc_local_datetime_shift_unit] ERROR");
			$finish;
		end
	end

	initial begin
		utcs_pkg::offset_t cur_offset;
		utcs_pkg::offset_t phase_offset;
		din_w.valid  <= 1'b0;
		din_w.action <= TO_LOCAL;
		din_w.year   <= '0;
		din_w.month  <= '0;
		din_w.day    <= '0;
		din_w.hour   <= '0;
		din_w.minute <= '0;
		din_w.second <= '0;
		cfg_we       <= 1'b0;
		cfg_wdata    <= '0;
		arst_n       <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// first rows run on the offset left by reset
		cur_offset = '0;
		for (int i = 0; i < N_DIRECTED; i++) begin
			if (STEPS[i].ofs != cur_offset) begin
				settle();
				load_offset(STEPS[i].ofs);
				cur_offset = STEPS[i].ofs;
			end
			offer_word(STEPS[i].word, STEPS[i].known, STEPS[i].want);
		end
		settle();

		for (int p = 0; p < N_PHASES; p++) begin
			case (p)
				0: phase_offset = utcs_pkg::offset_t'(0);
				1: phase_offset = utcs_pkg::offset_t'(840);
				2: phase_offset = utcs_pkg::offset_t'(-720);
				3: phase_offset = utcs_pkg::offset_t'(1023);
				4: phase_offset = utcs_pkg::offset_t'(-1024);
				7: phase_offset = utcs_pkg::offset_t'($urandom_range(2047));
				default: phase_offset = utcs_pkg::offset_t'(int'($urandom_range(1560)) - 720);
			endcase
			load_offset(phase_offset);
			no_idle = (p == 2);
			// sink stalls long enough for the pipeline to fill and push back
			if (p == 4)
				hold_dout_req = 1'b1;
			for (int k = 0; k < PHASE_WORDS; k++) begin
				if (p == 5 && k == PHASE_WORDS / 2)
					settle();
				if (!no_idle && $urandom_range(99) < 7) begin
					din_w.valid <= 1'b0;
					@(posedge clk);
				end
				offer_word(random_datetime(), 1'b0, '0);
			end
			settle();
		end
		no_idle = 1'b0;
		repeat (12) @(posedge clk);

		$display("run covered %0d directed rows and %0d random words over %0d offset loads",
			N_DIRECTED, N_PHASES * PHASE_WORDS, offsets_loaded);
		$display("%0d words checked, %0d mismatches", words_checked, mismatches);
		if (mismatches == 0)
			$display("[utc_local_datetime_shift_unit] OK");
		else
			$display("[utc_local_datetime_shift_unit] ERROR");
		$finish;
	end

endmodule
